// ----- src/crcfc_pkg.sv -----
// shared types, codes and the crc-8 byte update for the command framer / reply checker
package crcfc_pkg;

  // frame room in bytes, crc byte included
  localparam int FRAME_BYTES = 32;
  localparam logic [7:0] FRAME_SLOTS = 8'(FRAME_BYTES - 2);

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] ERR_FLAG = 8'h80;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_REQ  = 3'd1,
    PH_RLEN = 3'd2,
    PH_RPAY = 3'd3,
    PH_RCRC = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_REQ    = 2'd0,
    KIND_PAY    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ECHO = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_DEV_ERR  = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  // one result transaction
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    status_t     status;
    logic        last;
  } res_t;

  // results produced by one input transaction, r0 first
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // crc seeds for write and read address bytes
  typedef struct packed {
    logic [7:0] wr;
    logic [7:0] rd;
  } seed_t;

  // crc-8, msb first, no reflection, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- src/crcfc_cfg.sv -----
// device address register, kept as the precomputed crc of both address bytes
module crcfc_cfg
  import crcfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  output seed_t      seed
);

  seed_t seed_r;
  seed_t seed_nxt;

  // crc of write address byte and read address byte
  always_comb begin
    seed_nxt = seed_r;
    if (cfg_wr_en) begin
      seed_nxt.wr = crc8_byte(8'h00, {cfg_wr_data, 1'b0});
      seed_nxt.rd = crc8_byte(8'h00, {cfg_wr_data, 1'b1});
    end
  end

  // address zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r.wr <= crc8_byte(8'h00, 8'h00);
      seed_r.rd <= crc8_byte(8'h00, 8'h01);
    end else begin
      seed_r <= seed_nxt;
    end
  end

  assign seed = seed_r;

endmodule

// ----- src/crcfc_core.sv -----
// input register, packet state and per-byte framing / checking logic
module crcfc_core
  import crcfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  seed_t      seed,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_byte,
  input  logic       in_first,
  input  logic       in_last,
  input  logic [4:0] in_limit,
  input  logic       q_room,
  output push_t      push
);

  // input register
  logic       inv_r;
  logic       inv_nxt;
  logic       op_r;
  logic [7:0] byte_r;
  logic       first_r;
  logic       last_r;
  logic [4:0] limit_r;

  // packet state
  phase_t     phase_r, phase_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic       err_r, err_nxt;
  logic [7:0] dlen_r, dlen_nxt;
  logic [7:0] left_r, left_nxt;
  logic [4:0] lim_r, lim_nxt;

  logic       fire;
  logic       take;
  logic [7:0] crc_in;
  logic [7:0] left_dec;
  res_t       res0, res1;
  logic [1:0] n;

  assign fire     = inv_r && q_room;
  assign in_ready = !inv_r || q_room;
  assign left_dec = left_r - 8'd1;

  always_comb begin
    inv_nxt = inv_r;
    if (in_valid && in_ready) begin
      inv_nxt = 1'b1;
    end else if (fire) begin
      inv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else begin
      inv_r <= inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= in_op;
      byte_r  <= in_byte;
      first_r <= in_first;
      last_r  <= in_last;
      limit_r <= in_limit;
    end
  end

  // crc base for this byte: fresh seed on a packet start
  always_comb begin
    if (first_r) begin
      crc_in = op_r ? seed.rd : seed.wr;
    end else begin
      crc_in = crc_r;
    end
  end

  // state update and result generation
  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    cmd_nxt   = cmd_r;
    err_nxt   = err_r;
    dlen_nxt  = dlen_r;
    left_nxt  = left_r;
    lim_nxt   = lim_r;
    take      = 1'b0;
    n         = 2'd0;
    res0      = '{kind: KIND_REQ, data: byte_r, status: ST_OK, last: 1'b1};
    res1      = '{kind: KIND_REQ, data: 8'h00, status: ST_OK, last: 1'b1};

    if (!op_r) begin
      // request byte
      if (first_r || phase_r == PH_REQ) begin
        if (first_r) begin
          cmd_nxt   = byte_r;
          left_nxt  = FRAME_SLOTS;
          phase_nxt = PH_REQ;
          take      = 1'b1;
          crc_nxt   = crc_in;
        end else begin
          take = (left_r != 8'd0);
          if (take) begin
            left_nxt = left_dec;
          end
        end
        if (take) begin
          crc_nxt   = crc8_byte(crc_in, byte_r);
          res0.last = !last_r;
        end
        // crc appended after the last byte
        if (last_r) begin
          phase_nxt = PH_IDLE;
          if (take) begin
            n         = 2'd2;
            res1.data = crc_nxt;
          end else begin
            n         = 2'd1;
            res0.data = crc_nxt;
          end
        end else if (take) begin
          n = 2'd1;
        end
      end
    end else if (first_r) begin
      // echo byte opens a reply
      lim_nxt  = limit_r;
      crc_nxt  = crc8_byte(crc_in, byte_r);
      dlen_nxt = 8'd0;
      left_nxt = 8'd0;
      err_nxt  = 1'b0;
      if (byte_r == (cmd_r | ERR_FLAG)) begin
        err_nxt   = 1'b1;
        phase_nxt = PH_RLEN;
      end else if (byte_r == cmd_r) begin
        phase_nxt = PH_RLEN;
      end else begin
        phase_nxt = PH_IDLE;
        n         = 2'd1;
        res0      = '{kind: KIND_STATUS, data: 8'h00, status: ST_BAD_ECHO, last: 1'b1};
      end
    end else begin
      unique case (phase_r)
        PH_RLEN: begin
          crc_nxt  = crc8_byte(crc_r, byte_r);
          dlen_nxt = byte_r;
          if (err_r || byte_r == 8'd0) begin
            left_nxt  = 8'd0;
            phase_nxt = PH_RCRC;
          end else begin
            left_nxt  = byte_r;
            phase_nxt = PH_RPAY;
          end
        end
        PH_RPAY: begin
          crc_nxt  = crc8_byte(crc_r, byte_r);
          left_nxt = left_dec;
          if (dlen_r <= {3'b000, lim_r}) begin
            n    = 2'd1;
            res0 = '{kind: KIND_PAY, data: byte_r, status: ST_OK, last: 1'b1};
          end
          if (left_dec == 8'd0) begin
            phase_nxt = PH_RCRC;
          end
        end
        PH_RCRC: begin
          n         = 2'd1;
          phase_nxt = PH_IDLE;
          res0.kind = KIND_STATUS;
          res0.data = dlen_r;
          if (byte_r != crc_r) begin
            res0.data   = 8'h00;
            res0.status = ST_CRC_ERR;
          end else if (err_r) begin
            res0.status = ST_DEV_ERR;
          end else if (dlen_r > {3'b000, lim_r}) begin
            res0.status = ST_TOO_LONG;
          end else begin
            res0.status = ST_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      crc_r   <= 8'h00;
      cmd_r   <= 8'h00;
      err_r   <= 1'b0;
      dlen_r  <= 8'h00;
      left_r  <= 8'h00;
      lim_r   <= 5'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      cmd_r   <= cmd_nxt;
      err_r   <= err_nxt;
      dlen_r  <= dlen_nxt;
      left_r  <= left_nxt;
      lim_r   <= lim_nxt;
    end
  end

  assign push.n  = fire ? n : 2'd0;
  assign push.r0 = res0;
  assign push.r1 = res1;

endmodule

// ----- src/crcfc_outq.sv -----
// four-entry result queue, takes up to two results per cycle, gives one while out_ready is high
module crcfc_outq
  import crcfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  output logic       q_room,
  output logic [2:0] q_count,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  res_t       mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;
  logic [1:0] wr_ptr_1;

  assign pop      = (count_r != 3'd0) && out_ready;
  assign wr_ptr_1 = wr_ptr_r + 2'd1;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.n;
    rd_ptr_nxt = pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push.n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_1] <= push.r1;
    end
  end

  assign q_room    = (count_r <= 3'd2);
  assign q_count   = count_r;
  assign out_valid = (count_r != 3'd0);
  assign out_res   = mem_r[rd_ptr_r];

endmodule

// ----- src/command_frame_crc8_framer_checker.sv -----
// Command framer and reply checker with CRC-8 (poly 0x07, init 0), one byte per
// transaction. Request bytes pass through and the CRC follows the byte marked last;
// reply bytes are checked against the saved command, payload is forwarded and a
// status closes the reply. The block takes one input transaction per cycle unless
// held off; a last request byte that still fits the frame gives two results (the
// byte and the CRC), so such a transaction fills two queue entries. A four-entry
// result queue decouples the two sides; input is held off only while it has fewer
// than two free entries. Input bytes pass an input register, then the queue. The
// CRC update for one byte is a single table-free eight-step shift network per cycle.
module command_frame_crc8_framer_checker
  import crcfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration: device_address
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte[7:0], first[8], reply_limit[13:9], zero
  input  logic        in_tuser,   // op
  input  logic        in_tlast,   // last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte[7:0], status[10:8], zero
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // last_of_run
);

  seed_t      seed;
  push_t      push;
  logic       q_room;
  logic [2:0] q_count;
  res_t       out_res;

  crcfc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .seed        (seed)
  );

  crcfc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .seed     (seed),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_byte  (in_tdata[7:0]),
    .in_first (in_tdata[8]),
    .in_last  (in_tlast),
    .in_limit (in_tdata[13:9]),
    .q_room   (q_room),
    .push     (push)
  );

  crcfc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_room    (q_room),
    .q_count   (q_count),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'b00000, out_res.status, out_res.data};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  // queue never overfills
  assert property (@(posedge clk) disable iff (!rst_n) q_count <= 3'd4)
    else $error("result queue overflow");

  // a pair of results is a request byte then its crc, the crc closing the run
  assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> (!push.r0.last && push.r1.last && push.r0.kind == KIND_REQ &&
                        push.r1.kind == KIND_REQ))
    else $error("bad two-result transaction");

  // non-status results carry an ok status
  assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0 && push.r0.kind != KIND_STATUS) |-> push.r0.status == ST_OK)
    else $error("status on data result");

  // a push never arrives when the queue lacked room for two
  assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> q_count <= 3'd2)
    else $error("push without room");

endmodule

// ----- dv/command_frame_crc8_framer_checker_tb.sv -----
// testbench for the command framer / reply checker: random stream traffic with crc-8 prediction
`timescale 1ns / 1ps

module command_frame_crc8_framer_checker_tb;
  import crcfc_pkg::*;

  // one byte on the link side, as the stimulus sees it
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [4:0] limit;
  } link_byte_t;

  // one framed / checked result
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
    logic       last;
  } link_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  link_byte_t   pending_bytes[$];
  link_result_t due_results[$];
  link_byte_t   drv_next;
  link_result_t got_result;

  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  queued_count = 0;
  bit  calm = 1'b0;

  // stimulus-side view of the link
  logic [6:0] gen_addr = '0;
  logic [7:0] gen_cmd = '0;

  // model state
  logic [6:0] dev_addr = '0;
  logic [7:0] crc_run = '0;
  phase_t     link_phase = PH_IDLE;
  logic [7:0] saved_cmd = '0;
  logic       err_reply = 1'b0;
  logic [7:0] decl_len = '0;
  logic [7:0] remain = '0;
  logic [4:0] lim_held = '0;

  command_frame_crc8_framer_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // data_byte[7:0], first[8], reply_limit[13:9], zero
    .in_tuser   (in_tuser),   // op
    .in_tlast   (in_tlast),   // last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // out_byte[7:0], status[10:8], zero
    .out_tuser  (out_tuser),  // kind
    .out_tlast  (out_tlast)   // last_of_run
  );

  // 50 MHz clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // serial crc-8 update, one data bit per step, msb first
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  task automatic expect_result(input kind_t k, input logic [7:0] d, input status_t s,
                               input logic l);
    link_result_t r;
    r.kind = k;
    r.data = d;
    r.status = s;
    r.last = l;
    due_results.push_back(r);
  endtask

  // frame a request byte or check a reply byte, queue the results it causes
  task automatic frame_and_check(input link_byte_t t);
    bit take;
    take = 1'b0;
    if (!t.op) begin
      if (t.first) begin
        crc_run = crc_step(8'h00, {dev_addr, 1'b0});
        saved_cmd = t.data;
        remain = 8'(FRAME_BYTES - 2);
        link_phase = PH_REQ;
        take = 1'b1;
      end else if (link_phase == PH_REQ) begin
        take = (remain != 0);
        if (take) remain = remain - 8'd1;
      end else begin
        return;
      end
      if (take) begin
        crc_run = crc_step(crc_run, t.data);
        expect_result(KIND_REQ, t.data, ST_OK, !t.last);
      end
      if (t.last) begin
        expect_result(KIND_REQ, crc_run, ST_OK, 1'b1);
        link_phase = PH_IDLE;
      end
      return;
    end

    // reply side
    if (t.first) begin
      lim_held = t.limit;
      crc_run = crc_step(crc_step(8'h00, {dev_addr, 1'b1}), t.data);
      decl_len = '0;
      remain = '0;
      if (t.data == (saved_cmd | ERR_FLAG)) begin
        err_reply = 1'b1;
        link_phase = PH_RLEN;
      end else if (t.data == saved_cmd) begin
        err_reply = 1'b0;
        link_phase = PH_RLEN;
      end else begin
        err_reply = 1'b0;
        link_phase = PH_IDLE;
        expect_result(KIND_STATUS, 8'h00, ST_BAD_ECHO, 1'b1);
      end
      return;
    end
    case (link_phase)
      PH_RLEN: begin
        crc_run = crc_step(crc_run, t.data);
        decl_len = t.data;
        if (err_reply || t.data == 0) begin
          remain = '0;
          link_phase = PH_RCRC;
        end else begin
          remain = t.data;
          link_phase = PH_RPAY;
        end
      end
      PH_RPAY: begin
        crc_run = crc_step(crc_run, t.data);
        if (decl_len <= 8'(lim_held)) expect_result(KIND_PAY, t.data, ST_OK, 1'b1);
        remain = remain - 8'd1;
        if (remain == 0) link_phase = PH_RCRC;
      end
      PH_RCRC: begin
        if (t.data != crc_run) expect_result(KIND_STATUS, 8'h00, ST_CRC_ERR, 1'b1);
        else if (err_reply) expect_result(KIND_STATUS, decl_len, ST_DEV_ERR, 1'b1);
        else if (decl_len > 8'(lim_held)) expect_result(KIND_STATUS, decl_len, ST_TOO_LONG, 1'b1);
        else expect_result(KIND_STATUS, decl_len, ST_OK, 1'b1);
        link_phase = PH_IDLE;
      end
      default: begin
      end
    endcase
  endtask

  // input driver: next pending byte once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
        drv_next = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= drv_next.op;
        in_tlast  <= drv_next.last;
        in_tdata  <= {2'b00, drv_next.limit, drv_next.first, drv_next.data};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink backpressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= calm || ($urandom_range(99) >= 23);
  end

  // monitor: register mirror, prediction on input transactions, compare on output ones
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) dev_addr = cfg_wr_data;
      if (in_tvalid && in_tready)
        frame_and_check({in_tuser, in_tdata[7:0], in_tdata[8], in_tlast, in_tdata[13:9]});
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d, out_byte %0h, status %0d",
                 out_tuser, out_tdata[7:0], out_tdata[10:8]);
          mismatches++;
        end else begin
          got_result = due_results.pop_front();
          if (out_tuser !== got_result.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", got_result.kind, out_tuser);
            mismatches++;
          end
          if (out_tdata[7:0] !== got_result.data) begin
            $error("out_byte mismatch: expected %0h, actual %0h", got_result.data,
                   out_tdata[7:0]);
            mismatches++;
          end
          if (out_tdata[10:8] !== got_result.status) begin
            $error("status mismatch: expected %0d, actual %0d", got_result.status,
                   out_tdata[10:8]);
            mismatches++;
          end
          if (out_tlast !== got_result.last) begin
            $error("last_of_run mismatch: expected %0d, actual %0d", got_result.last,
                   out_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("command_frame_crc8_framer_checker test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic op, input logic [7:0] data, input logic first,
                           input logic last, input logic [4:0] limit);
    link_byte_t t;
    t = '{op, data, first, last, limit};
    pending_bytes.push_back(t);
    if (!op && first) gen_cmd = data;
    queued_count++;
  endtask

  // request: command, parameter count, parameters
  task automatic send_request(input logic [7:0] cmd, input int nparams, input bit close);
    int total;
    logic [7:0] b;
    total = nparams + 2;
    for (int i = 0; i < total; i++) begin
      b = (i == 0) ? cmd : (i == 1) ? 8'(nparams) : 8'($urandom_range(255));
      send_byte(1'b0, b, i == 0, close && (i == total - 1), 5'($urandom_range(29)));
    end
  endtask

  // reply: echo, length or error number, payload, crc; cut stops it early
  task automatic send_reply(input logic [7:0] echo, input logic [7:0] hdr,
                            input logic [4:0] limit, input bit corrupt, input int cut);
    logic [7:0] pkt[$];
    logic [7:0] c;
    int npay;
    int n;
    c = crc_step(8'h00, {gen_addr, 1'b1});
    pkt.push_back(echo);
    pkt.push_back(hdr);
    npay = (echo == (gen_cmd | ERR_FLAG) || hdr == 0) ? 0 : int'(hdr);
    for (int i = 0; i < npay; i++) pkt.push_back(8'($urandom_range(255)));
    foreach (pkt[i]) c = crc_step(c, pkt[i]);
    pkt.push_back(corrupt ? (c ^ 8'($urandom_range(1, 255))) : c);
    n = (cut >= 0 && cut < pkt.size()) ? cut : pkt.size();
    for (int i = 0; i < n; i++)
      send_byte(1'b1, pkt[i], i == 0, 1'($urandom_range(1)),
                (i == 0) ? limit : 5'($urandom_range(29)));
  endtask

  task automatic write_address(input logic [6:0] a);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= a;
    gen_addr = a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait until every byte is taken and every result is back, then let the pipe drain
  task automatic settle();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || due_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // mostly well-formed request/reply exchanges, some broken ones and noise
  task automatic run_traffic(input int budget);
    int start;
    int pick;
    int np;
    int len;
    logic [7:0] cmd;
    logic [7:0] e;
    start = queued_count;
    while (queued_count - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        cmd = 8'($urandom_range(255));
        if ($urandom_range(3) != 0) cmd[7] = 1'b0;
        np = ($urandom_range(14) == 0) ? $urandom_range(25, 40) : $urandom_range(6);
        send_request(cmd, np, $urandom_range(19) != 0);
        pick = $urandom_range(99);
        if (pick < 50) begin
          if ($urandom_range(7) == 0) len = 0;
          else if ($urandom_range(149) == 0) len = $urandom_range(41, 255);
          else if ($urandom_range(9) == 0) len = $urandom_range(13, 40);
          else len = $urandom_range(1, 12);
          send_reply(gen_cmd, 8'(len), 5'($urandom_range(29)), $urandom_range(7) == 0,
                     ($urandom_range(9) == 0) ? $urandom_range(1, len + 2) : -1);
        end else if (pick < 65) begin
          send_reply(gen_cmd | ERR_FLAG, 8'($urandom_range(255)), 5'($urandom_range(29)),
                     $urandom_range(5) == 0, -1);
        end else if (pick < 80) begin
          do e = 8'($urandom_range(255));
          while (e == gen_cmd || e == (gen_cmd | ERR_FLAG));
          send_reply(e, 8'h00, 5'($urandom_range(29)), 1'b0, 1);
        end
      end else begin
        // noise
        repeat ($urandom_range(1, 4))
          send_byte(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 5'($urandom_range(29)));
      end
    end
  endtask

  // reset, directed cases, then random phases at several addresses
  initial begin
    logic [6:0] a;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_address(7'h00);

    // two-byte request with extreme bytes, command with bit 7 set
    send_byte(1'b0, 8'hFF, 1'b1, 1'b0, 5'd0);
    send_byte(1'b0, 8'h00, 1'b0, 1'b1, 5'd29);
    // stray request byte, then stray reply byte
    send_byte(1'b0, 8'h5A, 1'b0, 1'b0, 5'd3);
    send_byte(1'b1, 8'hC3, 1'b0, 1'b1, 5'd7);
    // echo of a command with bit 7 set is taken as an error reply
    send_reply(8'hFF, 8'hA5, 5'd29, 1'b0, -1);
    // single-byte request, good reply
    send_byte(1'b0, 8'h12, 1'b1, 1'b1, 5'd0);
    send_reply(8'h12, 8'd2, 5'd29, 1'b0, -1);
    // reply abandoned by a new reply, which has a bad crc
    send_reply(8'h12, 8'd5, 5'd29, 1'b0, 1);
    send_reply(8'h92, 8'h07, 5'd0, 1'b1, -1);
    // bad echo
    send_reply(8'h34, 8'h00, 5'd0, 1'b0, 1);
    // payload over the limit, then an empty reply
    send_reply(8'h12, 8'd1, 5'd0, 1'b0, -1);
    send_reply(8'h12, 8'd0, 5'd29, 1'b0, -1);
    settle();

    for (int p = 0; p < 6; p++) begin
      a = (p == 0) ? 7'h7F : (p == 2) ? 7'h00 : 7'($urandom_range(127));
      write_address(a);
      calm = (p == 3);
      // one long request per phase to overrun the frame
      send_request(8'($urandom_range(127)), $urandom_range(30, 40), 1'b1);
      run_traffic(100);
      settle();
      calm = 1'b0;
    end

    if (mismatches == 0) begin
      $display("command_frame_crc8_framer_checker test passed");
    end else begin
      $display("command_frame_crc8_framer_checker test failed");
    end
    $finish;
  end

endmodule
